/* src/ncsg_pkg.sv */
`default_nettype none

package ncsg_pkg;

	localparam int SAMPLES_PER_PIXEL_DEF = 8;
	localparam int FRACTION_BITS_DEF = 14;

	localparam logic [3:0] PHASE_COUNT = 4'd12;
	localparam logic [3:0] HALF_PERIOD = 4'd6;
	localparam logic [3:0] HUE_LOW_ONLY = 4'h0C;
	localparam logic [3:0] HUE_FORCED = 4'h0D;
	localparam logic [3:0] HUE_HIGH_ONLY = 4'h0;
	localparam logic [3:0] EMPH_OFFSET_1 = 4'd4;
	localparam logic [3:0] EMPH_OFFSET_2 = 4'd8;

	localparam longint ATTEN_MILLI = 746;
	localparam longint UNITY_MILLI = 1000;
	localparam longint BLACK_MICRO = 518000;
	localparam longint SPAN_MICRO = 1444000;

	localparam int LEVEL_COUNT = 16;
	localparam int SAMPLE_W = 16;

	typedef struct packed {
		logic       valid;
		logic [8:0] pixel;
		logic [3:0] phase;
		logic [2:0] sample_index;
		logic       last;
	} ncsg_work_t;

	function automatic longint volt_milli(input int idx);
		case (idx)
			0: volt_milli = 350;
			1: volt_milli = 518;
			2: volt_milli = 962;
			3: volt_milli = 1550;
			4: volt_milli = 1094;
			5: volt_milli = 1506;
			6: volt_milli = 1962;
			default: volt_milli = 1962;
		endcase
	endfunction

	// Entry index is {attenuate, high voltage, level}.
	function automatic logic [LEVEL_COUNT*SAMPLE_W-1:0] build_levels(input int fb);
		longint micro;
		longint diff;
		longint mag;
		longint quo;
		logic [LEVEL_COUNT*SAMPLE_W-1:0] tbl;
		tbl = '0;
		for (int i = 0; i < LEVEL_COUNT; i++) begin
			micro = volt_milli(i % 8) * ((i >= 8) ? ATTEN_MILLI : UNITY_MILLI);
			diff = micro - BLACK_MICRO;
			mag = (diff < 0) ? -diff : diff;
			quo = ((mag << fb) + SPAN_MICRO / 2) / SPAN_MICRO;
			if (diff < 0) begin
				quo = -quo;
			end
			tbl[i*SAMPLE_W +: SAMPLE_W] = quo[SAMPLE_W-1:0];
		end
		return tbl;
	endfunction

	function automatic logic [3:0] phase_inc(input logic [3:0] ph);
		return (ph >= PHASE_COUNT - 4'd1) ? 4'd0 : ph + 4'd1;
	endfunction

	function automatic logic [3:0] phase_mod(input logic [3:0] v);
		return (v >= PHASE_COUNT) ? v - PHASE_COUNT : v;
	endfunction

	function automatic logic square_high(input logic [3:0] offset, input logic [3:0] ph);
		logic [4:0] sum;
		logic [4:0] red;
		sum = {1'b0, offset} + {1'b0, ph};
		if (sum >= {PHASE_COUNT, 1'b0}) begin
			red = sum - {PHASE_COUNT, 1'b0};
		end else if (sum >= {1'b0, PHASE_COUNT}) begin
			red = sum - {1'b0, PHASE_COUNT};
		end else begin
			red = sum;
		end
		return red < {1'b0, HALF_PERIOD};
	endfunction

endpackage

`default_nettype wire

/* src/ntsc_composite_signal_gen_core.sv */
// The first sample of a pixel is registered in the pixel register, then in the output register.
// Throughput: one sample per cycle while out_ready does not stall the output, set by
// the sample counter that steps the pixel register through its phases.
// A new pixel is taken in the cycle the last sample of the previous one enters the output register.
// Reset clears the subcarrier phase to zero and empties the pixel and output registers.
`default_nettype none

module ntsc_composite_signal_gen_core import ncsg_pkg::*; #(
	parameter int SAMPLES_PER_PIXEL = SAMPLES_PER_PIXEL_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [8:0]    pixel,
	input  wire logic          phase_load,
	input  wire logic [3:0]    phase_value,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic signed [15:0] sample,
	output logic [2:0]         sample_index,
	output logic               last
);

	ncsg_work_t work;
	logic       take;

	ncsg_sequencer #(
		.SAMPLES_PER_PIXEL(SAMPLES_PER_PIXEL)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.phase_load(phase_load),
		.phase_value(phase_value),
		.take(take),
		.work(work)
	);

	ncsg_level #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_level (
		.clk(clk),
		.arst_n(arst_n),
		.work(work),
		.take(take),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample(sample),
		.sample_index(sample_index),
		.last(last)
	);

endmodule

`default_nettype wire

/* src/ncsg_sequencer.sv */
`default_nettype none

module ncsg_sequencer import ncsg_pkg::*; #(
	parameter int SAMPLES_PER_PIXEL = SAMPLES_PER_PIXEL_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [8:0] pixel,
	input  wire logic       phase_load,
	input  wire logic [3:0] phase_value,
	input  wire logic       take,
	output ncsg_work_t      work
);

	localparam int IDX_W = (SAMPLES_PER_PIXEL > 1) ? $clog2(SAMPLES_PER_PIXEL) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES_PER_PIXEL - 1);

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [3:0]       phase_q;
	logic [8:0]       pixel_s1;
	logic             is_last;
	logic             step;
	logic             accept;
	logic [3:0]       phase_base;
	logic [3:0]       idx_wide;

	assign is_last = (idx_q == IDX_LAST);
	assign step = busy_q && take;
	assign in_ready = !busy_q || (take && is_last);
	assign accept = in_valid && in_ready;
	assign phase_base = step ? phase_inc(phase_q) : phase_q;
	assign idx_wide = 4'(idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			phase_q <= 4'd0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				idx_q <= '0;
				phase_q <= phase_load ? phase_mod(phase_value) : phase_base;
			end else if (step) begin
				phase_q <= phase_inc(phase_q);
				idx_q <= IDX_W'(idx_q + 1'b1);
				if (is_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
		end
	end

	always_comb begin
		work.valid = busy_q;
		work.pixel = pixel_s1;
		work.phase = phase_q;
		work.sample_index = idx_wide[2:0];
		work.last = is_last;
	end

endmodule

`default_nettype wire

/* src/ncsg_level.sv */
`default_nettype none

module ncsg_level import ncsg_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ncsg_work_t         work,
	output logic                    take,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      sample,
	output logic [2:0]              sample_index,
	output logic                    last
);

	localparam logic [LEVEL_COUNT*SAMPLE_W-1:0] LEVEL_TABLE = build_levels(FRACTION_BITS);

	logic [3:0] hue;
	logic [1:0] lvl;
	logic [2:0] emph;
	logic       sel_hi;
	logic       atten;
	logic [3:0] entry;
	logic       out_valid_q;

	always_comb begin
		hue = work.pixel[3:0];
		lvl = (hue > HUE_FORCED) ? 2'd1 : work.pixel[5:4];
		emph = work.pixel[8:6];
		if (hue == HUE_HIGH_ONLY) begin
			sel_hi = 1'b1;
		end else if (hue > HUE_LOW_ONLY) begin
			sel_hi = 1'b0;
		end else begin
			sel_hi = square_high(hue, work.phase);
		end
		atten = (hue <= HUE_FORCED) &&
			((emph[0] && square_high(4'd0, work.phase)) ||
			 (emph[1] && square_high(EMPH_OFFSET_1, work.phase)) ||
			 (emph[2] && square_high(EMPH_OFFSET_2, work.phase)));
		entry = {atten, sel_hi, lvl};
	end

	assign take = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= work.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && work.valid) begin
			sample <= LEVEL_TABLE[entry*SAMPLE_W +: SAMPLE_W];
			sample_index <= work.sample_index;
			last <= work.last;
		end
	end

endmodule

`default_nettype wire

/* verif/ncsg_checker.sv */
`timescale 1ns / 1ps

module ncsg_checker import ncsg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [8:0]  pixel,
	input  wire logic        phase_load,
	input  wire logic [3:0]  phase_value,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [15:0] sample,
	input  wire logic [2:0]  sample_index,
	input  wire logic        last,
	output int               pending,
	output int               mismatches,
	output int               pixels_seen,
	output int               samples_seen
);

	typedef struct packed {
		logic [15:0] level;
		logic [2:0]  index;
		logic        tail;
	} sample_word_t;

	localparam int PHASE_N = int'(PHASE_COUNT);

	longint level_volts [0:7] = '{350, 518, 962, 1550, 1094, 1506, 1962, 1962};
	sample_word_t expected_samples[$];
	sample_word_t want;
	int carrier_phase;
	int ph;

	initial begin
		pending = 0;
		mismatches = 0;
		pixels_seen = 0;
		samples_seen = 0;
		carrier_phase = 0;
	end

	function automatic logic in_high_half(input int offset, input int phase);
		return ((offset + phase) % PHASE_N) < int'(HALF_PERIOD);
	endfunction

	function automatic logic [15:0] composite_level(input logic [8:0] pix, input int phase);
		logic [3:0] hue;
		logic [1:0] lvl;
		logic [2:0] emph;
		logic dim;
		longint lo;
		longint hi;
		longint volts;
		longint diff;
		longint mag;
		longint quo;
		hue = pix[3:0];
		lvl = pix[5:4];
		emph = pix[8:6];
		if (hue > HUE_FORCED) begin
			lvl = 2'd1;
		end
		lo = level_volts[lvl];
		hi = level_volts[4 + lvl];
		if (hue == HUE_HIGH_ONLY) begin
			lo = hi;
		end
		if (hue > HUE_LOW_ONLY) begin
			hi = lo;
		end
		volts = in_high_half(int'(hue), phase) ? hi : lo;
		dim = (hue <= HUE_FORCED) &&
			((emph[0] && in_high_half(0, phase)) ||
			 (emph[1] && in_high_half(int'(EMPH_OFFSET_1), phase)) ||
			 (emph[2] && in_high_half(int'(EMPH_OFFSET_2), phase)));
		diff = volts * (dim ? ATTEN_MILLI : UNITY_MILLI) - BLACK_MICRO;
		mag = (diff < 0) ? -diff : diff;
		quo = ((mag << FRACTION_BITS_DEF) + SPAN_MICRO / 2) / SPAN_MICRO;
		if (diff < 0) begin
			quo = -quo;
		end
		return quo[15:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] exp_val);
		mismatches++;
		if (mismatches <= 25) begin
			$display("checker: %s got %h expected %h at %0t", what, got, exp_val, $realtime);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				ph = phase_load ? int'(phase_value) % PHASE_N : carrier_phase;
				for (int s = 0; s < SAMPLES_PER_PIXEL_DEF; s++) begin
					want.level = composite_level(pixel, (ph + s) % PHASE_N);
					want.index = s[2:0];
					want.tail = (s == SAMPLES_PER_PIXEL_DEF - 1);
					expected_samples.push_back(want);
				end
				carrier_phase = (ph + SAMPLES_PER_PIXEL_DEF) % PHASE_N;
				pixels_seen++;
			end
			if (out_valid && out_ready) begin
				samples_seen++;
				if (expected_samples.size() == 0) begin
					report_mismatch("sample transaction with nothing expected", sample, 16'h0);
				end else begin
					want = expected_samples.pop_front();
					if (sample !== want.level) begin
						report_mismatch("sample", sample, want.level);
					end
					if (sample_index !== want.index) begin
						report_mismatch("sample_index", {13'h0, sample_index}, {13'h0, want.index});
					end
					if (last !== want.tail) begin
						report_mismatch("last", {15'h0, last}, {15'h0, want.tail});
					end
				end
			end
			pending = expected_samples.size();
		end
	end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
	import ncsg_pkg::*;

	localparam int RANDOM_PIXELS = 360;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [8:0] pixel;
	logic phase_load;
	logic [3:0] phase_value;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] sample;
	logic [2:0] sample_index;
	logic last;

	int pending;
	int mismatches;
	int pixels_seen;
	int samples_seen;
	int burst_left;
	int stall_mode;
	int stall_left;
	int stall_tick;

	ntsc_composite_signal_gen_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.phase_load(phase_load),
		.phase_value(phase_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample(sample),
		.sample_index(sample_index),
		.last(last)
	);

	ncsg_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.phase_load(phase_load),
		.phase_value(phase_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample(sample),
		.sample_index(sample_index),
		.last(last),
		.pending(pending),
		.mismatches(mismatches),
		.pixels_seen(pixels_seen),
		.samples_seen(samples_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: errors");
		$finish;
	end

	initial begin
		stall_mode = 0;
		stall_left = 0;
		stall_tick = 0;
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 96);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			2: begin
				out_ready <= (stall_tick % 5 == 0);
			end
			default: begin
				out_ready <= ($urandom_range(0, 9) != 0);
			end
		endcase
	end

	task automatic send_pixel(input logic [8:0] pix, input logic load, input logic [3:0] pv);
		in_valid <= 1'b1;
		pixel <= pix;
		phase_load <= load;
		phase_value <= pv;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		pixel = '0;
		phase_load = 1'b0;
		phase_value = '0;
		out_ready = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_pixel(9'h000, 1'b1, 4'd0);
		send_pixel(9'h1FF, 1'b0, 4'd0);
		send_pixel(9'h1C0, 1'b1, 4'd11);
		send_pixel(9'h1FE, 1'b1, 4'd12);
		send_pixel(9'h0CD, 1'b1, 4'd15);
		send_pixel(9'h13F, 1'b1, 4'd13);
		send_pixel(9'h02E, 1'b1, 4'd14);
		for (int i = 0; i < 16; i++) begin
			send_pixel({i[2:0], i[3:2], i[3:0]}, (i % 5 == 0), i[3:0]);
		end

		burst_left = $urandom_range(1, 24);
		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			// Let the generator run dry once in the middle of the random traffic.
			if (i == RANDOM_PIXELS / 2) begin
				in_valid <= 1'b0;
				do @(negedge clk); while (pending != 0);
			end
			send_pixel(9'($urandom_range(0, 511)), ($urandom_range(0, 7) == 0),
				4'($urandom_range(0, 15)));
			burst_left--;
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) :
					$urandom_range(1, 12);
			end
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (10) @(negedge clk);

		$display("tb: %0d pixel transactions and %0d sample transactions checked,", pixels_seen,
			samples_seen);
		$display("tb: covering all hues, emphasis bits, phase reloads and output stalls");
		if (mismatches == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

/* sim.f */
src/ncsg_pkg.sv
src/ncsg_sequencer.sv
src/ncsg_level.sv
src/ntsc_composite_signal_gen_core.sv
verif/ncsg_checker.sv
verif/tb.sv
